@@ src/nfa_pkg.sv @@
// Shared types, sizes and codes of the NFA stream matcher.
// Used by nfa_front, nfa_back and nfa_epsilon_stream_matcher; no dependencies.
package nfa_pkg;

  localparam int STATES     = 16;
  localparam int MAX_STATES = 16;
  localparam int HW_STATES  = (STATES < MAX_STATES) ? STATES : MAX_STATES;

  localparam int CMD_W = 3;
  localparam int IDX_W = 4;
  localparam int SYM_W = 8;
  localparam int SET_W = 16;
  localparam int ST_W  = 2;

  localparam int CNT_W     = $clog2(HW_STATES + 1);
  localparam int PASS_W    = $clog2(HW_STATES);
  localparam int EIDX_W    = $clog2(HW_STATES);
  localparam int MOVE_AW   = IDX_W + SYM_W;
  localparam int MOVE_DEPTH = 1 << MOVE_AW;
  localparam int ALPHA_DEPTH = 1 << SYM_W;

  localparam logic [SET_W-1:0] SMASK = SET_W'((33'h1 << HW_STATES) - 33'h1);

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;

  // Command codes as they arrive.
  localparam logic [CMD_W-1:0] CMD_LOAD_MOVE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_EPS   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_ALPHA = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BEGIN      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SYMBOL     = 3'd4;

  // Work kinds after classification.
  localparam logic [CMD_W-1:0] K_MOVE  = 3'd0;
  localparam logic [CMD_W-1:0] K_EPS   = 3'd1;
  localparam logic [CMD_W-1:0] K_ALPHA = 3'd2;
  localparam logic [CMD_W-1:0] K_BEGIN = 3'd3;
  localparam logic [CMD_W-1:0] K_SYM   = 3'd4;
  localparam logic [CMD_W-1:0] K_NOP   = 3'd5;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_LIVE   = 2'd1;
  localparam logic [ST_W-1:0] ST_BADSYM = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL = 1'd1;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  typedef struct packed {
    logic [CMD_W-1:0] kind;
    logic [IDX_W-1:0] idx;
    logic [SYM_W-1:0] sym;
    logic [SET_W-1:0] mask;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } head_t;

  typedef struct packed {
    logic pop;
    logic open;
  } back_ctl_t;

endpackage

@@ src/nfa_front.sv @@
// Front end of the NFA matcher: accepts items, classifies them, queues them.
// Depends on nfa_pkg.
module nfa_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [nfa_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [nfa_pkg::CMD_W-1:0]         in_tuser,
  input  nfa_pkg::back_ctl_t                ctl,
  output nfa_pkg::head_t                    head
);
  import nfa_pkg::*;

  item_t          q_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic           push;
  item_t          cls;
  logic [IDX_W-1:0] idx_in;
  logic [SYM_W-1:0] sym_in;
  logic [SET_W-1:0] mask_in;
  logic           idx_ok;

  assign idx_in  = in_tdata[IDX_W-1:0];
  assign sym_in  = in_tdata[IDX_W+SYM_W-1:IDX_W];
  assign mask_in = in_tdata[IDX_W+SYM_W+SET_W-1:IDX_W+SYM_W];
  assign idx_ok  = (32'(idx_in) < HW_STATES);

  // Classify: drop loads to missing states and unused commands to no-ops.
  always_comb begin
    cls.idx  = idx_in;
    cls.sym  = sym_in;
    cls.mask = mask_in & SMASK;
    case (in_tuser)
      CMD_LOAD_MOVE:  cls.kind = idx_ok ? K_MOVE : K_NOP;
      CMD_LOAD_EPS:   cls.kind = idx_ok ? K_EPS : K_NOP;
      CMD_LOAD_ALPHA: cls.kind = K_ALPHA;
      CMD_BEGIN:      cls.kind = K_BEGIN;
      CMD_SYMBOL:     cls.kind = K_SYM;
      default:        cls.kind = K_NOP;
    endcase
  end

  assign in_tready = ctl.open && (cnt_r != Q_CW'(Q_DEPTH));
  assign push      = in_tvalid && in_tready;

  assign head.vld  = (cnt_r != '0);
  assign head.item = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push    ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = ctl.pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CW'(push) - Q_CW'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> cnt_r != '0) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CW'(Q_DEPTH)) else $error("queue count overflow");
  a_move_idx: assert property (@(posedge clk) disable iff (!rst_n)
    head.vld && (head.item.kind == K_MOVE || head.item.kind == K_EPS)
      |-> 32'(head.item.idx) < HW_STATES) else $error("load to missing state queued");
`endif

endmodule

@@ src/nfa_back.sv @@
// Back end of the NFA matcher: stores, move union, epsilon closure, result register.
// Depends on nfa_pkg.
module nfa_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [nfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nfa_pkg::SET_W-1:0]         cfg_wdata,
  input  nfa_pkg::head_t                    head,
  output nfa_pkg::back_ctl_t                ctl,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [nfa_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import nfa_pkg::*;

  localparam logic [1:0] BS_CLEAR = 2'd0;
  localparam logic [1:0] BS_IDLE  = 2'd1;
  localparam logic [1:0] BS_MOVE  = 2'd2;
  localparam logic [1:0] BS_CLOS  = 2'd3;

  logic [SET_W-1:0] move_mem  [MOVE_DEPTH];
  logic             alpha_mem [ALPHA_DEPTH];
  logic [SET_W-1:0] eps_r     [HW_STATES];

  logic [1:0]         state_r, state_nxt;
  logic [MOVE_AW-1:0] clr_r, clr_nxt;
  logic [SET_W-1:0]   start_r, final_r;
  logic [SET_W-1:0]   active_r, active_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic               begin_r, begin_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PASS_W-1:0]  pass_r, pass_nxt;
  logic [SET_W-1:0]   acc_r, acc_nxt;
  logic [SET_W-1:0]   set_r, set_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [ST_W-1:0]    out_st_r, out_st_nxt;
  logic [SET_W-1:0]   out_set_r, out_set_nxt;
  logic               out_acc_r;

  logic [SET_W-1:0]   mv_q_r;
  logic               alpha_q_r;
  logic               mv_we, al_we, eps_we;
  logic [MOVE_AW-1:0] mv_waddr, mv_raddr;
  logic [SET_W-1:0]   mv_wdata;
  logic [SYM_W-1:0]   al_waddr;
  logic               al_wdata;
  logic               pop;
  logic [SET_W-1:0]   eps_or, grown, acc_add;
  logic               src_bit;

  assign mv_raddr = {IDX_W'(cnt_r), sym_r};
  assign src_bit  = active_r[IDX_W'(CNT_W'(cnt_r - 1'b1))];
  assign acc_add  = src_bit ? mv_q_r : '0;

  // One closure pass: add the epsilon targets of every state in the set.
  always_comb begin
    eps_or = '0;
    for (int s = 0; s < HW_STATES; s++) begin
      if (set_r[s]) begin
        eps_or = eps_or | eps_r[s];
      end
    end
    grown = (set_r | eps_or) & SMASK;
  end

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    active_nxt  = active_r;
    sym_nxt     = sym_r;
    begin_nxt   = begin_r;
    cnt_nxt     = cnt_r;
    pass_nxt    = pass_r;
    acc_nxt     = acc_r;
    set_nxt     = set_r;
    out_vld_nxt = out_vld_r && !out_tready;
    out_st_nxt  = out_st_r;
    out_set_nxt = out_set_r;
    pop         = 1'b0;
    mv_we       = 1'b0;
    mv_waddr    = {head.item.idx, head.item.sym};
    mv_wdata    = head.item.mask;
    al_we       = 1'b0;
    al_waddr    = head.item.sym;
    al_wdata    = head.item.mask[0];
    eps_we      = 1'b0;
    case (state_r)
      BS_CLEAR: begin
        mv_we    = 1'b1;
        mv_waddr = clr_r;
        mv_wdata = '0;
        al_we    = 1'b1;
        al_waddr = clr_r[SYM_W-1:0];
        al_wdata = 1'b0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == MOVE_AW'(MOVE_DEPTH - 1)) begin
          state_nxt = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (head.vld && !out_vld_r) begin
          pop     = 1'b1;
          sym_nxt = head.item.sym;
          cnt_nxt = '0;
          pass_nxt = '0;
          acc_nxt = '0;
          case (head.item.kind)
            K_MOVE: begin
              mv_we = 1'b1;
            end
            K_EPS: begin
              eps_we = 1'b1;
            end
            K_ALPHA: begin
              al_we = 1'b1;
            end
            default: begin
            end
          endcase
          if (head.item.kind == K_BEGIN) begin
            begin_nxt = 1'b1;
            set_nxt   = start_r & SMASK;
            state_nxt = BS_CLOS;
          end else if (head.item.kind == K_SYM) begin
            begin_nxt = 1'b0;
            state_nxt = BS_MOVE;
          end else begin
            out_vld_nxt = 1'b1;
            out_st_nxt  = ST_DONE;
            out_set_nxt = active_r;
          end
        end
      end
      BS_MOVE: begin
        // Read one source row a cycle; accumulate the row read last cycle.
        if (cnt_r != '0) begin
          acc_nxt = acc_r | acc_add;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(HW_STATES)) begin
          if (!alpha_q_r) begin
            active_nxt  = '0;
            out_vld_nxt = 1'b1;
            out_st_nxt  = ST_BADSYM;
            out_set_nxt = '0;
            state_nxt   = BS_IDLE;
          end else begin
            set_nxt   = (acc_r | acc_add) & SMASK;
            state_nxt = BS_CLOS;
          end
        end
      end
      BS_CLOS: begin
        pass_nxt = pass_r + 1'b1;
        set_nxt  = grown;
        if (grown == set_r || pass_r == PASS_W'(HW_STATES - 1)) begin
          active_nxt  = grown;
          out_vld_nxt = 1'b1;
          out_set_nxt = grown;
          out_st_nxt  = begin_r ? ST_DONE : ((grown != '0) ? ST_LIVE : ST_EMPTY);
          state_nxt   = BS_IDLE;
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BS_CLEAR;
      clr_r     <= '0;
      active_r  <= '0;
      out_vld_r <= 1'b0;
      start_r   <= SET_W'(1);
      final_r   <= '0;
      for (int s = 0; s < HW_STATES; s++) begin
        eps_r[s] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      active_r  <= active_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we && cfg_index == CFG_START) begin
        start_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_FINAL) begin
        final_r <= cfg_wdata;
      end
      if (eps_we) begin
        eps_r[EIDX_W'(head.item.idx)] <= head.item.mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    sym_r     <= sym_nxt;
    begin_r   <= begin_nxt;
    cnt_r     <= cnt_nxt;
    pass_r    <= pass_nxt;
    acc_r     <= acc_nxt;
    set_r     <= set_nxt;
    out_st_r  <= out_st_nxt;
    out_set_r <= out_set_nxt;
    out_acc_r <= |(out_set_nxt & final_r & SMASK);
  end

  // Move and alphabet stores: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (mv_we) begin
      move_mem[mv_waddr] <= mv_wdata;
    end
    mv_q_r <= move_mem[mv_raddr];
  end

  always_ff @(posedge clk) begin
    if (al_we) begin
      alpha_mem[al_waddr] <= al_wdata;
    end
    alpha_q_r <= alpha_mem[sym_r];
  end

  assign ctl.pop    = pop;
  assign ctl.open   = (state_r != BS_CLEAR);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W - ST_W - SET_W - 1){1'b0}}, out_acc_r, out_set_r, out_st_r};

`ifndef SYNTHESIS
  a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BS_CLEAR |-> !pop) else $error("item taken during clearing pass");
  a_badsym_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_st_r == ST_BADSYM |-> out_set_r == '0)
    else $error("rejected symbol left states active");
  a_live_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_st_r == ST_LIVE |-> out_set_r != '0)
    else $error("live status with empty set");
  a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> out_set_r == active_r)
    else $error("result set differs from active set");
`endif

endmodule

@@ src/nfa_epsilon_stream_matcher.sv @@
// Top level of the bit-vector NFA matcher with epsilon closure.
// Instantiates nfa_front and nfa_back; depends on nfa_pkg.
//
//  channel   direction  handshake             payload
//  in_*      slave      in_tvalid/in_tready   tuser: cmd; tdata: state_index, symbol, mask
//  out_*     master     out_tvalid/out_tready tdata: status, active_set, accepted
//  cfg_*     write      cfg_we                cfg_index, cfg_wdata (start_mask, final_mask)
//
// Work: loads and unused commands finish in the back end's idle state; begin runs
// the closure passes; a symbol reads the move row of every state through the single
// read port of the move store, then runs the closure passes (a byte outside the
// alphabet ends after the reads). The closure unit does one pass a cycle; the next
// item starts the cycle after the result is taken.
// Reset: a clearing pass zeroes every entry of the move and alphabet stores,
// with in_tready low; configuration writes are taken throughout.
// Stalls: a two-entry queue lets the front accept while the back works, and
// the result register holds until out_tready.
module nfa_epsilon_stream_matcher (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // bits [3:0] state_index, [11:4] symbol, [27:12] mask, [31:28] zero
  input  logic [nfa_pkg::IN_DATA_W-1:0]     in_tdata,
  // bits [2:0] cmd
  input  logic [nfa_pkg::CMD_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // bits [1:0] status, [17:2] active_set, [18] accepted, [23:19] zero
  output logic [nfa_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [nfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nfa_pkg::SET_W-1:0]         cfg_wdata
);
  import nfa_pkg::*;

  head_t     head;
  back_ctl_t ctl;

  // Accept, classify and queue items.
  nfa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .ctl       (ctl),
    .head      (head)
  );

  // Execute queued items and hold each result until taken.
  nfa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .ctl        (ctl),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ tb/sv/nfa_epsilon_stream_matcher_test.sv @@
// Testbench for nfa_epsilon_stream_matcher: directed and random command streams
// checked item by item against a bit-vector NFA predictor kept in this module.
// Depends on nfa_pkg and the RTL top level only.
`timescale 1ns / 100ps

module nfa_epsilon_stream_matcher_test;
  import nfa_pkg::*;

  // Cycles with no accepted item before the run is declared hung. The clearing
  // pass after reset keeps in_tready low while it runs.
  localparam int WATCHDOG_LIMIT = 20000;
  // Longest item: a symbol plus a full closure.
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 125;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [SET_W-1:0] active;
    logic             accepted;
  } match_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [SET_W-1:0]      cfg_wdata = '0;

  // Predictor copy of the matcher: registers, the three stores and the set.
  logic [SET_W-1:0] start_reg;
  logic [SET_W-1:0] final_reg;
  logic [SET_W-1:0] move_rows [HW_STATES][ALPHA_DEPTH];
  logic [SET_W-1:0] eps_rows [HW_STATES];
  logic             alpha_bits [ALPHA_DEPTH];
  logic [SET_W-1:0] live_set;

  match_result_t expected_matches[$];
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  int            stall_left = 0;
  logic          gaps_on = 1'b1;
  logic          stalls_on = 1'b1;

  nfa_epsilon_stream_matcher u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Grow a set along epsilon edges, one pass per step, until it stops growing.
  function automatic logic [SET_W-1:0] close_eps(logic [SET_W-1:0] set);
    logic [SET_W-1:0] grown;
    set = set & SMASK;
    for (int pass = 0; pass < HW_STATES; pass++) begin
      grown = set;
      for (int s = 0; s < HW_STATES; s++)
        if (set[s]) grown = grown | eps_rows[s];
      grown = grown & SMASK;
      if (grown == set) break;
      set = grown;
    end
    return set;
  endfunction

  // Union of the move rows of every active state for one byte.
  function automatic logic [SET_W-1:0] follow_moves(logic [SET_W-1:0] set,
                                                     logic [SYM_W-1:0] sym);
    logic [SET_W-1:0] nxt;
    nxt = '0;
    for (int s = 0; s < HW_STATES; s++)
      if (set[s]) nxt = nxt | move_rows[s][sym];
    return nxt & SMASK;
  endfunction

  // Apply one item to the predictor and return the result it must produce.
  function automatic match_result_t nfa_step(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                             logic [SYM_W-1:0] sym, logic [SET_W-1:0] mask);
    match_result_t r;
    logic          idx_ok;
    logic [SET_W-1:0] nxt;
    r.status = ST_DONE;
    idx_ok = (int'(idx) < HW_STATES);
    case (cmd)
      CMD_LOAD_MOVE: if (idx_ok) move_rows[idx][sym] = mask & SMASK;
      CMD_LOAD_EPS:  if (idx_ok) eps_rows[idx] = mask & SMASK;
      CMD_LOAD_ALPHA: alpha_bits[sym] = mask[0];
      CMD_BEGIN:     live_set = close_eps(start_reg);
      CMD_SYMBOL: begin
        if (!alpha_bits[sym]) begin
          live_set = '0;
          r.status = ST_BADSYM;
        end else begin
          nxt = close_eps(follow_moves(live_set, sym));
          live_set = nxt;
          r.status = (nxt != '0) ? ST_LIVE : ST_EMPTY;
        end
      end
      default: ;
    endcase
    r.active = live_set;
    r.accepted = |(live_set & final_reg & SMASK);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle length: mostly short, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A sparse state set: one to four random states.
  function automatic logic [SET_W-1:0] sparse_set();
    logic [SET_W-1:0] m;
    m = '0;
    repeat ($urandom_range(1, 4)) m = m | (SET_W'(1) << $urandom_range(0, SET_W - 1));
    return m;
  endfunction

  // Send one item: optional gap, record its expected result, hold until taken.
  // Valid stays high on return so back-to-back items need no drop in between.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [SYM_W-1:0] sym, input logic [SET_W-1:0] mask);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 35) ? gap_len() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    expected_matches.push_back(nfa_step(cmd, idx, sym, mask));
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_DATA_W'({mask, sym, idx});
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid, wait for every expected result, then let the back end settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both mask registers; only called with the block idle.
  task automatic set_masks(input logic [SET_W-1:0] start_v, input logic [SET_W-1:0] final_v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START;
    cfg_wdata <= start_v;
    @(posedge clk);
    cfg_index <= CFG_FINAL;
    cfg_wdata <= final_v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    start_reg = start_v;
    final_reg = final_v;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset contents: symbols before any begin, unused commands, default start.
  task automatic test_power_on();
    send_item(CMD_SYMBOL, 4'h0, 8'h00, 16'h0000);
    send_item(3'd5, 4'hF, 8'hFF, 16'hFFFF);
    send_item(3'd6, 4'h0, 8'h00, 16'h0000);
    send_item(3'd7, 4'hA, 8'h55, 16'hAAAA);
    send_item(CMD_BEGIN, 4'h0, 8'h00, 16'h0000);
    send_item(CMD_SYMBOL, 4'hF, 8'hFF, 16'hFFFF);
    wait_idle();
  endtask

  // Field extremes, every load kind, multi-pass closure, both rejections and
  // a table rewrite in the middle of a string.
  task automatic test_table_paths();
    set_masks(16'h0001, 16'h8000);
    send_item(CMD_LOAD_ALPHA, 4'h0, 8'hFF, 16'hFFFF);
    send_item(CMD_LOAD_ALPHA, 4'hF, 8'h00, 16'h0001);
    send_item(CMD_LOAD_ALPHA, 4'h3, 8'h5A, 16'hFFFE);   // bit 0 clear: not a member
    send_item(CMD_LOAD_MOVE, 4'h0, 8'hFF, 16'h0002);
    send_item(CMD_LOAD_MOVE, 4'hF, 8'h00, 16'hFFFF);
    send_item(CMD_LOAD_EPS, 4'h1, 8'h00, 16'h8000);
    send_item(CMD_LOAD_EPS, 4'hF, 8'hFF, 16'h0001);
    send_item(CMD_BEGIN, 4'h0, 8'h00, 16'h0000);
    send_item(CMD_SYMBOL, 4'h0, 8'hFF, 16'h0000);       // closes over 1 -> 15 -> 0
    send_item(CMD_SYMBOL, 4'h0, 8'h00, 16'h0000);       // state 15 fans out to all
    send_item(CMD_SYMBOL, 4'h0, 8'h5A, 16'h0000);       // outside the alphabet
    send_item(CMD_SYMBOL, 4'h0, 8'h00, 16'h0000);       // after rejection: no states
    send_item(CMD_BEGIN, 4'h0, 8'h00, 16'h0000);
    send_item(CMD_LOAD_MOVE, 4'h0, 8'hFF, 16'h0000);    // rewrite mid-string
    send_item(CMD_SYMBOL, 4'h0, 8'hFF, 16'h0000);
    wait_idle();
  endtask

  // Register extremes: empty start set, then every state a start and a final.
  task automatic test_start_extremes();
    set_masks(16'h0000, 16'hFFFF);
    send_item(CMD_BEGIN, 4'h0, 8'h00, 16'h0000);
    send_item(CMD_SYMBOL, 4'h0, 8'h00, 16'h0000);
    wait_idle();
    set_masks(16'hFFFF, 16'hFFFF);
    send_item(CMD_BEGIN, 4'h0, 8'h00, 16'h0000);
    send_item(CMD_SYMBOL, 4'h0, 8'h00, 16'h0000);
    wait_idle();
  endtask

  // Random NFAs over a small alphabet, then strings that mostly stay in it,
  // with mid-string rewrites and raw noise mixed in.
  task automatic test_random_strings();
    logic [SYM_W-1:0] sigma [6];
    int               n_sigma;
    int               sent;
    int               len;
    int               pick;
    logic [SYM_W-1:0] sym;
    logic [SET_W-1:0] start_v;
    logic [SET_W-1:0] final_v;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      gaps_on   = (ph % 4 != 0);
      stalls_on = (ph % 3 != 0);
      case (ph)
        0:       begin start_v = 16'hFFFF;   final_v = 16'h0000; end
        1:       begin start_v = sparse_set(); final_v = 16'hFFFF; end
        default: begin
          start_v = sparse_set();
          final_v = (ph % 2 == 0) ? sparse_set() : SET_W'($urandom_range(0, 65535));
        end
      endcase
      set_masks(start_v, final_v);
      sent = 0;

      // Build the automaton.
      n_sigma = $urandom_range(2, 6);
      for (int k = 0; k < n_sigma; k++) begin
        sigma[k] = SYM_W'($urandom_range(0, 255));
        send_item(CMD_LOAD_ALPHA, IDX_W'($urandom_range(0, 15)), sigma[k],
                  {SET_W'($urandom_range(0, 65535)) | 16'h0001});
        sent++;
      end
      if ($urandom_range(0, 1) == 1) begin
        send_item(CMD_LOAD_ALPHA, IDX_W'($urandom_range(0, 15)),
                  SYM_W'($urandom_range(0, 255)),
                  {SET_W'($urandom_range(0, 65535)) & 16'hFFFE});
        sent++;
      end
      repeat (32) begin
        send_item(CMD_LOAD_MOVE, IDX_W'($urandom_range(0, 15)),
                  sigma[$urandom_range(0, n_sigma - 1)],
                  ($urandom_range(0, 9) == 0) ? 16'h0000 : sparse_set());
        sent++;
      end
      repeat (4) begin
        send_item(CMD_LOAD_EPS, IDX_W'($urandom_range(0, 15)),
                  SYM_W'($urandom_range(0, 255)),
                  ($urandom_range(0, 1) == 0) ? 16'h0000 : sparse_set());
        sent++;
      end

      // Run strings against it.
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          send_item(CMD_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 15)),
                    SYM_W'($urandom_range(0, 255)), SET_W'($urandom_range(0, 65535)));
          sent++;
        end else if (pick < 12) begin
          send_item(CMD_LOAD_MOVE, IDX_W'($urandom_range(0, 15)),
                    sigma[$urandom_range(0, n_sigma - 1)], sparse_set());
          sent++;
        end else begin
          send_item(CMD_BEGIN, IDX_W'($urandom_range(0, 15)),
                    SYM_W'($urandom_range(0, 255)), SET_W'($urandom_range(0, 65535)));
          sent++;
          len = $urandom_range(1, 12);
          for (int j = 0; j < len; j++) begin
            sym = ($urandom_range(0, 99) < 90) ? sigma[$urandom_range(0, n_sigma - 1)]
                                               : SYM_W'($urandom_range(0, 255));
            send_item(CMD_SYMBOL, IDX_W'($urandom_range(0, 15)), sym,
                      SET_W'($urandom_range(0, 65535)));
            sent++;
          end
        end
      end
      wait_idle();
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, checker, watchdog
  // ---------------------------------------------------------------------------

  // Hold out_tready low for random stretches; no new ones start while stalls are off.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 99) < 25) begin
      stall_left <= gap_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin
    match_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_matches.size() == 0) begin
        $error("result with nothing expected: out_tdata %h", out_tdata);
        mismatch_count++;
      end else begin
        want = expected_matches.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[1:0]);
          mismatch_count++;
        end
        if (out_tdata[17:2] !== want.active) begin
          $error("active_set: expected %h, got %h", want.active, out_tdata[17:2]);
          mismatch_count++;
        end
        if (out_tdata[18] !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_tdata[18]);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when no item moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Predictor starts from the reset contents.
    start_reg = 16'h0001;
    final_reg = 16'h0000;
    live_set  = '0;
    foreach (move_rows[s, b]) move_rows[s][b] = '0;
    foreach (eps_rows[s]) eps_rows[s] = '0;
    foreach (alpha_bits[b]) alpha_bits[b] = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_power_on();
    test_table_paths();
    test_start_extremes();
    test_random_strings();
    wait_idle();

    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
